// File: src/mse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRIME = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// File: src/mse_bank.sv
`timescale 1ns / 1ps
`default_nettype none

module mse_bank
  import mse_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [VALUE_W-1:0] wdata,
  input  wire logic [AW-1:0]      raddr_a,
  input  wire logic [AW-1:0]      raddr_b,
  output logic      [VALUE_W-1:0] rdata_a,
  output logic      [VALUE_W-1:0] rdata_b
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: src/merge_sort_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Stable ascending merge sort of up to DEPTH signed 32-bit values. Values load
// one per cycle while busy is low; an item with last_in set ends the set and
// raises busy. Values beyond DEPTH are dropped and flagged by overflow on every
// result of that run. The sort runs ceil(log2 n) passes over two ping-pong
// banks with a single comparator, one element per cycle plus a priming state
// (ST_PRIME) before each pass; the merge rate is set by that comparator and
// the one write port of each bank. Results then stream out one per cycle on
// strobe, with last_out on the final one. The receiver cannot stall: each
// result is valid for exactly the one cycle that strobe is high. Busy falls as
// the final result is read, so a new set may start while it is still being
// presented.
module merge_sort_engine_core
  import mse_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire item_t   item,
  output logic         strobe,
  output result_t      result
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = CW + 2;

  state_t state;

  logic [CW-1:0] count;
  logic          dropped;

  logic [PW-1:0] i, j, k, mid, hi, width;
  logic          src;
  logic          last_d, ovf_d, sel_d;

  logic [VALUE_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
  logic [VALUE_W-1:0] rd_i, rd_j, merge_data;
  logic [AW-1:0]      raddr_a, raddr_b;

  logic               accept, room, take_i, run_end, pass_end;
  logic [CW-1:0]      n_new;
  logic [PW-1:0]      n_ext, i_step, j_step, k_step, i_rd, j_rd;
  logic [PW-1:0]      width2, run_mid, run_hi;

  logic               we0, we1;
  logic [AW-1:0]      waddr0;
  logic [VALUE_W-1:0] wdata0;

  function automatic logic [PW-1:0] min_p(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  assign accept = start && (state == ST_IDLE);
  assign room   = count < CW'(DEPTH);
  assign n_new  = room ? count + CW'(1) : count;
  assign n_ext  = PW'(count);

  always_comb begin
    rd_i       = src ? rd1_a : rd0_a;
    rd_j       = src ? rd1_b : rd0_b;
    take_i     = (i < mid) && ((j >= hi) || ($signed(rd_i) <= $signed(rd_j)));
    merge_data = take_i ? rd_i : rd_j;
    i_step     = i + PW'(take_i);
    j_step     = j + PW'(!take_i);
    k_step     = k + PW'(1);
    run_end    = (k_step == hi);
    pass_end   = run_end && (hi == n_ext);
    width2     = width << 1;
    run_mid    = min_p(hi + width, n_ext);
    run_hi     = min_p(hi + width2, n_ext);
    if (run_end) begin
      i_rd = hi;
      j_rd = run_mid;
    end else begin
      i_rd = i_step;
      j_rd = j_step;
    end
  end

  always_comb begin
    case (state)
      ST_PRIME: begin
        raddr_a = i[AW-1:0];
        raddr_b = j[AW-1:0];
      end
      ST_MERGE: begin
        raddr_a = i_rd[AW-1:0];
        raddr_b = j_rd[AW-1:0];
      end
      ST_OUT: begin
        raddr_a = k[AW-1:0];
        raddr_b = j[AW-1:0];
      end
      default: begin
        raddr_a = i[AW-1:0];
        raddr_b = j[AW-1:0];
      end
    endcase
  end

  assign we0    = (accept && room) || ((state == ST_MERGE) && src);
  assign waddr0 = (state == ST_IDLE) ? count[AW-1:0] : k[AW-1:0];
  assign wdata0 = (state == ST_IDLE) ? VALUE_W'(item.value) : merge_data;
  assign we1    = (state == ST_MERGE) && !src;

  mse_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  mse_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (k[AW-1:0]),
    .wdata   (merge_data),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= (state == ST_OUT);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (item.last_in) begin
              src   <= 1'b0;
              k     <= '0;
              width <= PW'(1);
              i     <= '0;
              mid   <= PW'(1);
              j     <= PW'(1);
              hi    <= min_p(PW'(2), PW'(n_new));
              if (n_new <= CW'(1)) begin
                state <= ST_OUT;
              end else begin
                state <= ST_PRIME;
              end
            end
          end
        end
        ST_PRIME: begin
          state <= ST_MERGE;
        end
        ST_MERGE: begin
          k <= k_step;
          i <= i_rd;
          j <= j_rd;
          if (run_end) begin
            mid <= run_mid;
            hi  <= run_hi;
          end
          if (pass_end) begin
            src   <= ~src;
            width <= width2;
            k     <= '0;
            i     <= '0;
            mid   <= width2;
            j     <= width2;
            hi    <= min_p(width2 << 1, n_ext);
            if (width2 >= n_ext) begin
              state <= ST_OUT;
            end else begin
              state <= ST_PRIME;
            end
          end
        end
        ST_OUT: begin
          k      <= k_step;
          last_d <= (k_step == n_ext);
          ovf_d  <= dropped;
          sel_d  <= src;
          if (k_step == n_ext) begin
            state   <= ST_IDLE;
            count   <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy                = (state != ST_IDLE);
  assign result.sorted_value = sel_d ? rd1_a : rd0_a;
  assign result.last_out     = last_d;
  assign result.overflow     = ovf_d;

endmodule

`default_nettype wire

// File: src/mse_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mse_checker
  import mse_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire item_t   item,
  input wire logic    strobe,
  input wire result_t result
);

  a_load_stays_ready: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.last_in) |=> !busy)
    else $error("loading beat raised busy");

  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last_in) |=> busy)
    else $error("closing beat did not raise busy");

  a_results_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_out) |=> strobe)
    else $error("gap inside result run");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_out) |=> !strobe)
    else $error("result after final beat");

  a_busy_during_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_out) |-> busy)
    else $error("idle before final result");

endmodule

bind merge_sort_engine_core mse_checker u_mse_checker (.*);

`default_nettype wire
